[rtl/sensor_record_average_convert_top_defines.svh]
// Assertion macros used by the checker file of the block.
`ifndef SENSOR_RECORD_AVERAGE_CONVERT_TOP_DEFINES_SVH
`define SENSOR_RECORD_AVERAGE_CONVERT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SRAC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SRAC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/srac_pkg.sv]
`default_nettype none

package srac_pkg;

  localparam int SUM_W      = 32;
  localparam int CNT_W      = 16;
  localparam int RAW_W      = 16;
  localparam int VAL_W      = 30;
  localparam int FLAG_W     = 4;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 4;

  localparam int unsigned REG_MV_SCALE   = 1000;
  localparam int unsigned REG_MV_SHIFT   = 13;
  localparam int unsigned CUR_SCALE      = 10000;
  localparam int unsigned MON_MV_SHIFT   = 3;
  localparam int unsigned MON_MV_STEP_SH = 2;

  localparam int REG_PROD_W = RAW_W + 10;
  localparam int REGV_W     = REG_PROD_W - int'(REG_MV_SHIFT);

  localparam logic [CNT_W-1:0] SHUNT_RESET = 16'd1000;

  localparam int FLG_REG_V = 0;
  localparam int FLG_TEMP  = 1;
  localparam int FLG_MON_V = 2;
  localparam int FLG_CUR   = 3;

  localparam logic [1:0] UNIT_MV    = 2'd0;
  localparam logic [1:0] UNIT_DEG_C = 2'd1;
  localparam logic [1:0] UNIT_MA    = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNKNOWN    = 2'd1;
  localparam logic [1:0] ST_ZERO_SHUNT = 2'd2;

  typedef enum logic [2:0] {
    KIND_REG_V,
    KIND_TEMP,
    KIND_MON_V,
    KIND_CUR,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] divisor;
    kind_e            kind;
    logic             last;
  } rec_t;

endpackage

`default_nettype wire

[rtl/sensor_record_average_convert_top.sv]
// Sensor record averaging and unit conversion.
// The input stream carries one collection record per word: tdata holds the
// 32-bit sum and the 16-bit sample count, tuser the four record type flags
// and tlast the end of a readout burst. The output stream returns one word
// per record with the converted average in tdata, unit and status in tuser
// and the copied end marker in tlast. The shunt register is written with
// cfg_we_i and cfg_wdata_i; the user must write it only while no record is
// in flight, as the block itself does not enforce this. One record is
// taken every cycle while the output is not stalled; the 32 stages of the
// averaging divider and the 30 stages of the current divider each retire
// one quotient bit per cycle, so both run at full rate.
// A front register and a small queue take records while the back pipeline
// waits. When the receiver stalls, the output word holds and the whole back
// pipeline freezes; the input keeps accepting until the queue is full.
// Reset empties the pipeline and the queue and sets the shunt to 1000.
`default_nettype none

module sensor_record_average_convert_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,   // shunt_micro_ohms
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // sum_of_samples [31:0], sample_count [47:32]
  input  logic [3:0]  s_axis_tuser,  // is_reg_voltage, is_temperature, is_mon_voltage,
                                     // is_mon_current from bit 0 up
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // average_value [29:0], zero fill [31:30]
  output logic [3:0]  m_axis_tuser,  // unit_kind [1:0], status [3:2]
  output logic        m_axis_tlast
);

  logic [srac_pkg::CNT_W-1:0] shunt_q;

  srac_pkg::rec_t front_rec;
  logic           front_vld;
  logic           q_ready;
  srac_pkg::rec_t q_rec;
  logic           q_vld;
  logic           q_pop;

  logic [srac_pkg::VAL_W-1:0] value;
  logic [1:0]                 unit;
  logic [1:0]                 status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shunt_q <= srac_pkg::SHUNT_RESET;
    end else if (cfg_we_i) begin
      shunt_q <= cfg_wdata_i;
    end
  end

  srac_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .sum_i      (s_axis_tdata[31:0]),
    .cnt_i      (s_axis_tdata[47:32]),
    .flags_i    (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .rec_o      (front_rec),
    .rec_valid_o(front_vld),
    .q_ready_i  (q_ready)
  );

  srac_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_vld),
    .data_i (front_rec),
    .ready_o(q_ready),
    .pop_i  (q_pop),
    .data_o (q_rec),
    .valid_o(q_vld)
  );

  srac_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shunt_i    (shunt_q),
    .rec_i      (q_rec),
    .rec_valid_i(q_vld),
    .rec_pop_o  (q_pop),
    .value_o    (value),
    .unit_o     (unit),
    .status_o   (status),
    .last_o     (m_axis_tlast),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, value};
  assign m_axis_tuser = {status, unit};

endmodule

`default_nettype wire

[rtl/srac_div_step.sv]
`default_nettype none

module srac_div_step #(
  parameter int DW = 16
) (
  input  logic [DW-1:0] rem_i,
  input  logic          bit_i,
  input  logic [DW-1:0] div_i,
  output logic [DW-1:0] rem_o,
  output logic          q_o
);

  logic [DW:0] trial;
  logic [DW:0] diff;

  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, div_i};
  assign q_o   = (trial >= {1'b0, div_i});
  assign rem_o = q_o ? diff[DW-1:0] : trial[DW-1:0];

endmodule

`default_nettype wire

[rtl/srac_front.sv]
`default_nettype none

module srac_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [srac_pkg::SUM_W-1:0]    sum_i,
  input  logic [srac_pkg::CNT_W-1:0]    cnt_i,
  input  logic [srac_pkg::FLAG_W-1:0]   flags_i,
  input  logic                          last_i,
  output srac_pkg::rec_t                rec_o,
  output logic                          rec_valid_o,
  input  logic                          q_ready_i
);

  srac_pkg::rec_t rec_d;
  srac_pkg::rec_t rec_q;
  logic           vld_q;
  logic           accept;

  assign s_ready_o   = !vld_q || q_ready_i;
  assign accept      = s_valid_i && s_ready_o;
  assign rec_o       = rec_q;
  assign rec_valid_o = vld_q;

  always_comb begin
    rec_d.sum     = sum_i;
    rec_d.divisor = (cnt_i == '0) ? srac_pkg::CNT_W'(1) : cnt_i;
    rec_d.last    = last_i;
    if (flags_i[srac_pkg::FLG_REG_V]) begin
      rec_d.kind = srac_pkg::KIND_REG_V;
    end else if (flags_i[srac_pkg::FLG_TEMP]) begin
      rec_d.kind = srac_pkg::KIND_TEMP;
    end else if (flags_i[srac_pkg::FLG_MON_V]) begin
      rec_d.kind = srac_pkg::KIND_MON_V;
    end else if (flags_i[srac_pkg::FLG_CUR]) begin
      rec_d.kind = srac_pkg::KIND_CUR;
    end else begin
      rec_d.kind = srac_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (q_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rec_q <= rec_d;
    end
  end

endmodule

`default_nettype wire

[rtl/srac_queue.sv]
`default_nettype none

module srac_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srac_pkg::rec_t data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output srac_pkg::rec_t data_o,
  output logic           valid_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  srac_pkg::rec_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  logic            pop;

  assign ready_o = (cnt_q != CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign push    = push_i && ready_o;
  assign pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/srac_back.sv]
`default_nettype none

module srac_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [srac_pkg::CNT_W-1:0]    shunt_i,
  input  srac_pkg::rec_t                rec_i,
  input  logic                          rec_valid_i,
  output logic                          rec_pop_o,
  output logic [srac_pkg::VAL_W-1:0]    value_o,
  output logic [1:0]                    unit_o,
  output logic [1:0]                    status_o,
  output logic                          last_o,
  output logic                          valid_o,
  input  logic                          ready_i
);

  localparam int NumA  = srac_pkg::SUM_W;
  localparam int NumB  = srac_pkg::VAL_W;
  localparam int CntW  = srac_pkg::CNT_W;
  localparam int SumW  = srac_pkg::SUM_W;
  localparam int RawW  = srac_pkg::RAW_W;
  localparam int ValW  = srac_pkg::VAL_W;
  localparam int RegW  = srac_pkg::REGV_W;
  localparam int ProdW = srac_pkg::REG_PROD_W;

  logic adv;
  logic out_vld_q;

  assign adv       = !out_vld_q || ready_i;
  assign rec_pop_o = adv && rec_valid_i;

  // Average: one quotient bit of sum / count per stage.
  logic               a_vld_q  [NumA];
  logic [CntW-1:0]    a_rem_q  [NumA];
  logic [CntW-1:0]    a_div_q  [NumA];
  logic [SumW-1:0]    a_num_q  [NumA];
  logic [RawW-1:0]    a_quo_q  [NumA];
  srac_pkg::kind_e    a_kind_q [NumA];
  logic               a_last_q [NumA];

  for (genvar k = 0; k < NumA; k++) begin : g_a
    logic            vld_in;
    logic [CntW-1:0] rem_in;
    logic [CntW-1:0] div_in;
    logic [SumW-1:0] num_in;
    logic [RawW-1:0] quo_in;
    srac_pkg::kind_e kind_in;
    logic            last_in;
    logic [CntW-1:0] rem_nx;
    logic            q_bit;

    if (k == 0) begin : g_src
      assign vld_in  = rec_valid_i;
      assign rem_in  = '0;
      assign div_in  = rec_i.divisor;
      assign num_in  = rec_i.sum;
      assign quo_in  = '0;
      assign kind_in = rec_i.kind;
      assign last_in = rec_i.last;
    end else begin : g_src
      assign vld_in  = a_vld_q[k-1];
      assign rem_in  = a_rem_q[k-1];
      assign div_in  = a_div_q[k-1];
      assign num_in  = a_num_q[k-1];
      assign quo_in  = a_quo_q[k-1];
      assign kind_in = a_kind_q[k-1];
      assign last_in = a_last_q[k-1];
    end

    srac_div_step #(
      .DW(CntW)
    ) u_step (
      .rem_i(rem_in),
      .bit_i(num_in[SumW-1]),
      .div_i(div_in),
      .rem_o(rem_nx),
      .q_o  (q_bit)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q[k] <= 1'b0;
      end else if (adv) begin
        a_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        a_rem_q[k]  <= rem_nx;
        a_div_q[k]  <= div_in;
        a_num_q[k]  <= {num_in[SumW-2:0], 1'b0};
        a_quo_q[k]  <= {quo_in[RawW-2:0], q_bit};
        a_kind_q[k] <= kind_in;
        a_last_q[k] <= last_in;
      end
    end
  end

  // Constant scaling of the average.
  logic [RawW-1:0]  raw;
  logic [ProdW-1:0] reg_prod;
  logic [ValW-1:0]  cur_prod;

  logic             m_vld_q;
  logic [ValW-1:0]  m_cur_q;
  logic [RegW-1:0]  m_regv_q;
  logic [RawW-1:0]  m_raw_q;
  srac_pkg::kind_e  m_kind_q;
  logic             m_last_q;

  assign raw      = a_quo_q[NumA-1];
  assign reg_prod = ProdW'(raw) * ProdW'(srac_pkg::REG_MV_SCALE);
  assign cur_prod = ValW'(raw) * ValW'(srac_pkg::CUR_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= a_vld_q[NumA-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_cur_q  <= cur_prod;
      m_regv_q <= reg_prod[ProdW-1:srac_pkg::REG_MV_SHIFT];
      m_raw_q  <= raw;
      m_kind_q <= a_kind_q[NumA-1];
      m_last_q <= a_last_q[NumA-1];
    end
  end

  // Current: one quotient bit of the scaled average / shunt per stage.
  logic               b_vld_q  [NumB];
  logic [CntW-1:0]    b_rem_q  [NumB];
  logic [ValW-1:0]    b_num_q  [NumB];
  logic [ValW-1:0]    b_quo_q  [NumB];
  logic [RegW-1:0]    b_regv_q [NumB];
  logic [RawW-1:0]    b_raw_q  [NumB];
  srac_pkg::kind_e    b_kind_q [NumB];
  logic               b_last_q [NumB];

  for (genvar k = 0; k < NumB; k++) begin : g_b
    logic            vld_in;
    logic [CntW-1:0] rem_in;
    logic [ValW-1:0] num_in;
    logic [ValW-1:0] quo_in;
    logic [RegW-1:0] regv_in;
    logic [RawW-1:0] raw_in;
    srac_pkg::kind_e kind_in;
    logic            last_in;
    logic [CntW-1:0] rem_nx;
    logic            q_bit;

    if (k == 0) begin : g_src
      assign vld_in  = m_vld_q;
      assign rem_in  = '0;
      assign num_in  = m_cur_q;
      assign quo_in  = '0;
      assign regv_in = m_regv_q;
      assign raw_in  = m_raw_q;
      assign kind_in = m_kind_q;
      assign last_in = m_last_q;
    end else begin : g_src
      assign vld_in  = b_vld_q[k-1];
      assign rem_in  = b_rem_q[k-1];
      assign num_in  = b_num_q[k-1];
      assign quo_in  = b_quo_q[k-1];
      assign regv_in = b_regv_q[k-1];
      assign raw_in  = b_raw_q[k-1];
      assign kind_in = b_kind_q[k-1];
      assign last_in = b_last_q[k-1];
    end

    srac_div_step #(
      .DW(CntW)
    ) u_step (
      .rem_i(rem_in),
      .bit_i(num_in[ValW-1]),
      .div_i(shunt_i),
      .rem_o(rem_nx),
      .q_o  (q_bit)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_vld_q[k] <= 1'b0;
      end else if (adv) begin
        b_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        b_rem_q[k]  <= rem_nx;
        b_num_q[k]  <= {num_in[ValW-2:0], 1'b0};
        b_quo_q[k]  <= {quo_in[ValW-2:0], q_bit};
        b_regv_q[k] <= regv_in;
        b_raw_q[k]  <= raw_in;
        b_kind_q[k] <= kind_in;
        b_last_q[k] <= last_in;
      end
    end
  end

  // Result selection and output register.
  logic [ValW-1:0] val_d;
  logic [1:0]      unit_d;
  logic [1:0]      st_d;
  logic [RawW-1:0] raw_b;

  logic [ValW-1:0] val_q;
  logic [1:0]      unit_q;
  logic [1:0]      st_q;
  logic            last_q;

  assign raw_b = b_raw_q[NumB-1];

  always_comb begin
    val_d  = '0;
    unit_d = srac_pkg::UNIT_MV;
    st_d   = srac_pkg::ST_OK;
    unique case (b_kind_q[NumB-1])
      srac_pkg::KIND_REG_V: begin
        val_d = ValW'(b_regv_q[NumB-1]);
      end
      srac_pkg::KIND_TEMP: begin
        val_d  = ValW'(raw_b);
        unit_d = srac_pkg::UNIT_DEG_C;
      end
      srac_pkg::KIND_MON_V: begin
        val_d = ValW'(raw_b >> srac_pkg::MON_MV_SHIFT) << srac_pkg::MON_MV_STEP_SH;
      end
      srac_pkg::KIND_CUR: begin
        unit_d = srac_pkg::UNIT_MA;
        if (shunt_i == '0) begin
          st_d = srac_pkg::ST_ZERO_SHUNT;
        end else begin
          val_d = b_quo_q[NumB-1];
        end
      end
      default: begin
        st_d = srac_pkg::ST_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= b_vld_q[NumB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      val_q  <= val_d;
      unit_q <= unit_d;
      st_q   <= st_d;
      last_q <= b_last_q[NumB-1];
    end
  end

  assign value_o  = val_q;
  assign unit_o   = unit_q;
  assign status_o = st_q;
  assign last_o   = last_q;
  assign valid_o  = out_vld_q;

endmodule

`default_nettype wire

[rtl/srac_checker.sv]
`default_nettype none

`include "sensor_record_average_convert_top_defines.svh"

module srac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [15:0] cfg_wdata_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [3:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        stall;
  logic [36:0] out_word;
  logic [1:0]  unit;
  logic [1:0]  status;
  logic        unknown;
  logic        zero_shunt;
  logic        temp;
  logic [47:0] unused_in;

  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign out_word   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign unit       = m_axis_tuser[1:0];
  assign status     = m_axis_tuser[3:2];
  assign unknown    = m_axis_tvalid && (status == srac_pkg::ST_UNKNOWN);
  assign zero_shunt = m_axis_tvalid && (status == srac_pkg::ST_ZERO_SHUNT);
  assign temp       = m_axis_tvalid && (unit == srac_pkg::UNIT_DEG_C);
  assign unused_in  = s_axis_tdata ^ {s_axis_tuser, s_axis_tlast, s_axis_tvalid,
                      s_axis_tready, cfg_we_i, cfg_wdata_i, 24'd0};

  `SRAC_ASSERT_NXT(a_out_hold, stall, m_axis_tvalid && $stable(out_word), "output word changed in stall")
  `SRAC_ASSERT_IMP(a_unknown, unknown, (m_axis_tdata == '0) && (unit == srac_pkg::UNIT_MV), "bad unknown")
  `SRAC_ASSERT_IMP(a_zshunt, zero_shunt, (m_axis_tdata == '0) && (unit == srac_pkg::UNIT_MA), "bad shunt")
  `SRAC_ASSERT_IMP(a_temp, temp, (m_axis_tdata[31:16] == '0) && (status == srac_pkg::ST_OK), "bad temp")

endmodule

bind sensor_record_average_convert_top srac_checker u_srac_checker (.*);

`default_nettype wire
